// ----- hdl/checksum_frame_receiver_core_defines.svh -----
// Assertion macros shared by the checksum frame receiver RTL.
`ifndef CHECKSUM_FRAME_RECEIVER_CORE_DEFINES_SVH
`define CHECKSUM_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CFR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checksum frame receiver assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checksum frame receiver assertion failed");

`endif

// ----- hdl/cfr_pkg.sv -----
// Shared constants and types of the checksum frame receiver.
package cfr_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_HEADER    = 3'd0,
        CFG_SECOND_HEADER   = 3'd1,
        CFG_TAIL_BYTE       = 3'd2,
        CFG_HEADER_TIMEOUT  = 3'd3,
        CFG_PAYLOAD_TIMEOUT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  first_header;
        logic [7:0]  second_header;
        logic [7:0]  tail_byte;
        logic [15:0] header_timeout;
        logic [15:0] payload_timeout;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [7:0]       command;
        logic [LEN_W-1:0] length;
    } frame_start_t;

endpackage

// ----- hdl/checksum_frame_receiver_core.sv -----
// Top level of the checksum frame receiver: configuration registers, parser, store and drain.
//
// Input channel: in_valid/in_stall carry one beat per item, either a received byte
// (operation 0, rx_byte) or one timer tick (operation 1). While no frame is being
// delivered the block takes one beat per cycle.
// Output channel: out_valid/out_stall carry one result beat per payload byte of a good
// frame (command, payload_length, byte_index, data_byte, last), or a single beat with
// data_byte 0 for an empty frame.
// The first result appears in the cycle after the tail byte's beat is accepted, and the
// results follow one per cycle while out_stall stays low. Delivery of a frame is paced
// by the single read port of the payload store; in_stall is high for that whole run
// and the next input beat is taken in the cycle after the last result beat.
// When the receiver holds out_stall, the current result beat stays on the port
// unchanged and the store is not read again until the beat is taken.
// Configuration: cfg_write with cfg_index and cfg_data writes one register per cycle.
// Reset (rst_n low, asynchronous) returns the parser to header hunting, empties the
// output and restores the register defaults; the payload store is not cleared.
module checksum_frame_receiver_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [7:0]                    rx_byte,
    input  logic                          cfg_write,
    input  logic [cfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cfr_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    command,
    output logic [cfr_pkg::LEN_W-1:0]     payload_length,
    output logic [cfr_pkg::ADDR_W-1:0]    byte_index,
    output logic [7:0]                    data_byte,
    output logic                          last
);

    `include "checksum_frame_receiver_core_defines.svh"

    cfr_pkg::cfg_t              cfg_reg;
    cfr_pkg::frame_start_t      start;
    logic                       in_accept;
    logic                       busy;
    logic                       wr_en;
    logic [cfr_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                 wr_data;
    logic                       rd_en;
    logic [cfr_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                 rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_header    <= 8'd170;
            cfg_reg.second_header   <= 8'd85;
            cfg_reg.tail_byte       <= 8'd13;
            cfg_reg.header_timeout  <= 16'd10;
            cfg_reg.payload_timeout <= 16'd20;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cfr_pkg::CFG_FIRST_HEADER:    cfg_reg.first_header    <= cfg_data[7:0];
                cfr_pkg::CFG_SECOND_HEADER:   cfg_reg.second_header   <= cfg_data[7:0];
                cfr_pkg::CFG_TAIL_BYTE:       cfg_reg.tail_byte       <= cfg_data[7:0];
                cfr_pkg::CFG_HEADER_TIMEOUT:  cfg_reg.header_timeout  <= cfg_data;
                cfr_pkg::CFG_PAYLOAD_TIMEOUT: cfg_reg.payload_timeout <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input is held off while a frame drains, so store writes and reads never overlap.
    assign in_stall  = busy;
    assign in_accept = in_valid && !in_stall;

    cfr_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .operation (operation),
        .rx_byte   (rx_byte),
        .cfg       (cfg_reg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .start     (start)
    );

    cfr_ram #(
        .WIDTH (8),
        .DEPTH (cfr_pkg::MAX_PAYLOAD)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cfr_drain u_drain (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .out_stall      (out_stall),
        .rd_data        (rd_data),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .busy           (busy),
        .out_valid      (out_valid),
        .command        (command),
        .payload_length (payload_length),
        .byte_index     (byte_index),
        .data_byte      (data_byte),
        .last           (last)
    );

    `CFR_ASSERT_IMPL(a_no_input_while_draining, out_valid, in_stall)
    `CFR_ASSERT_NEXT(a_index_advances, out_valid && !last && !out_stall,
        out_valid && byte_index == cfr_pkg::ADDR_W'($past(byte_index) + 1'b1))
    `CFR_ASSERT_NEXT(a_run_ends_on_last, out_valid && last && !out_stall, !out_valid)
    `CFR_ASSERT_IMPL(a_no_store_write_while_draining, busy, !wr_en)

endmodule

// ----- hdl/cfr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/cfr_parse.sv -----
// Frame parser: hunts for the header, checks the frame and writes payload bytes to the store.
module cfr_parse (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_accept,
    input  logic                      operation,
    input  logic [7:0]                rx_byte,
    input  cfr_pkg::cfg_t             cfg,
    output logic                      wr_en,
    output logic [cfr_pkg::ADDR_W-1:0] wr_addr,
    output logic [7:0]                wr_data,
    output cfr_pkg::frame_start_t     start
);

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_SUM    = 5'b01000,
        PH_TAIL   = 5'b10000
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [cfr_pkg::LEN_W-1:0]   count_reg, count_next;
    logic [7:0]                  command_reg, command_next;
    logic [cfr_pkg::LEN_W-1:0]   length_reg, length_next;
    logic [7:0]                  sum_reg, sum_next;
    logic                        header_ok_reg, header_ok_next;
    logic [7:0]                  rx_sum_reg, rx_sum_next;
    logic [15:0]                 tick_reg, tick_next;
    logic [15:0]                 limit;
    logic [cfr_pkg::LEN_W-1:0]   count_inc;

    assign limit     = (phase_reg == PH_HEADER) ? cfg.header_timeout : cfg.payload_timeout;
    assign count_inc = count_reg + cfr_pkg::LEN_W'(1);
    assign wr_addr   = count_reg[cfr_pkg::ADDR_W-1:0];
    assign wr_data   = rx_byte;

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        command_next   = command_reg;
        length_next    = length_reg;
        sum_next       = sum_reg;
        header_ok_next = header_ok_reg;
        rx_sum_next    = rx_sum_reg;
        tick_next      = tick_reg;
        wr_en          = 1'b0;
        start.valid    = 1'b0;
        start.command  = command_reg;
        start.length   = length_reg;

        if (in_accept && operation)
        begin
            // A tick only matters while a frame is in progress.
            if (phase_reg != PH_HUNT)
            begin
                if (tick_reg >= limit)
                begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_reg + 16'd1;
                end
            end
        end
        else if (in_accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == cfg.first_header)
                    begin
                        phase_next     = PH_HEADER;
                        count_next     = '0;
                        tick_next      = '0;
                        sum_next       = rx_byte;
                        header_ok_next = 1'b0;
                    end
                end
                PH_HEADER:
                begin
                    sum_next = sum_reg + rx_byte;
                    if (count_reg == cfr_pkg::LEN_W'(0))
                    begin
                        header_ok_next = (rx_byte == cfg.second_header);
                        count_next     = cfr_pkg::LEN_W'(1);
                    end
                    else if (count_reg == cfr_pkg::LEN_W'(1))
                    begin
                        command_next = rx_byte;
                        count_next   = cfr_pkg::LEN_W'(2);
                    end
                    else if (!header_ok_reg || rx_byte > 8'(cfr_pkg::MAX_PAYLOAD))
                    begin
                        phase_next = PH_HUNT;
                        count_next = '0;
                        tick_next  = '0;
                    end
                    else
                    begin
                        length_next = rx_byte[cfr_pkg::LEN_W-1:0];
                        count_next  = '0;
                        tick_next   = '0;
                        phase_next  = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    wr_en      = 1'b1;
                    sum_next   = sum_reg + rx_byte;
                    count_next = count_inc;
                    if (count_inc >= length_reg)
                    begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    rx_sum_next = rx_byte;
                    phase_next  = PH_TAIL;
                end
                PH_TAIL:
                begin
                    start.valid = (rx_sum_reg == sum_reg) && (rx_byte == cfg.tail_byte);
                    phase_next  = PH_HUNT;
                    count_next  = '0;
                    tick_next   = '0;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                    count_next = '0;
                    tick_next  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            count_reg     <= '0;
            command_reg   <= '0;
            length_reg    <= '0;
            sum_reg       <= '0;
            header_ok_reg <= 1'b0;
            rx_sum_reg    <= '0;
            tick_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            command_reg   <= command_next;
            length_reg    <= length_next;
            sum_reg       <= sum_next;
            header_ok_reg <= header_ok_next;
            rx_sum_reg    <= rx_sum_next;
            tick_reg      <= tick_next;
        end
    end

endmodule

// ----- hdl/cfr_drain.sv -----
// Frame drain: reads a good frame's payload from the store, one beat per cycle unless stalled.
module cfr_drain (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfr_pkg::frame_start_t      start,
    input  logic                       out_stall,
    input  logic [7:0]                 rd_data,
    output logic                       rd_en,
    output logic [cfr_pkg::ADDR_W-1:0] rd_addr,
    output logic                       busy,
    output logic                       out_valid,
    output logic [7:0]                 command,
    output logic [cfr_pkg::LEN_W-1:0]  payload_length,
    output logic [cfr_pkg::ADDR_W-1:0] byte_index,
    output logic [7:0]                 data_byte,
    output logic                       last
);

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_SHOW = 2'b10
    } drain_state_t;

    drain_state_t                state_reg, state_next;
    logic [cfr_pkg::ADDR_W-1:0]  index_reg, index_next;
    logic [7:0]                  command_reg, command_next;
    logic [cfr_pkg::LEN_W-1:0]   length_reg, length_next;
    logic                        out_accept;
    logic                        is_last;

    assign out_accept = (state_reg == D_SHOW) && !out_stall;
    assign is_last    = (length_reg == '0) ||
                        (cfr_pkg::LEN_W'(index_reg) + cfr_pkg::LEN_W'(1) == length_reg);

    always_comb
    begin
        state_next   = state_reg;
        index_next   = index_reg;
        command_next = command_reg;
        length_next  = length_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;
        case (state_reg)
            D_IDLE:
            begin
                if (start.valid)
                begin
                    rd_en        = 1'b1;
                    index_next   = '0;
                    command_next = start.command;
                    length_next  = start.length;
                    state_next   = D_SHOW;
                end
            end
            D_SHOW:
            begin
                if (out_accept)
                begin
                    if (is_last)
                    begin
                        state_next = D_IDLE;
                    end
                    else
                    begin
                        // Fetch the next byte now so it is on the output right after this beat.
                        rd_en      = 1'b1;
                        rd_addr    = index_reg + cfr_pkg::ADDR_W'(1);
                        index_next = index_reg + cfr_pkg::ADDR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= D_IDLE;
            index_reg   <= '0;
            command_reg <= '0;
            length_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            index_reg   <= index_next;
            command_reg <= command_next;
            length_reg  <= length_next;
        end
    end

    assign busy           = (state_reg != D_IDLE);
    assign out_valid      = (state_reg == D_SHOW);
    assign command        = command_reg;
    assign payload_length = length_reg;
    assign byte_index     = index_reg;
    assign data_byte      = (length_reg == '0) ? 8'd0 : rd_data;
    assign last           = is_last;

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for checksum_frame_receiver_core with a built-in deframing predictor.
`timescale 1ns / 1ps

module tb;
    import cfr_pkg::*;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;
    localparam int LONG_HOLD = 400;

    typedef enum logic [2:0] {
        SEEK_H1,
        TAKE_HDR,
        TAKE_DATA,
        TAKE_SUM,
        TAKE_TAIL
    } rx_state_t;

    typedef enum int {
        FR_CLEAN,
        FR_WRONG_H2,
        FR_WRONG_SUM,
        FR_WRONG_TAIL,
        FR_OVERSIZE,
        FR_HDR_TIMEOUT,
        FR_PAY_TIMEOUT
    } frame_kind_t;

    typedef struct packed {
        logic       op;
        logic [7:0] value;
    } beat_t;

    typedef struct packed {
        logic [7:0]        cmd;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] idx;
        logic [7:0]        data;
        logic              last;
    } frame_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  operation = OP_BYTE;
    logic [7:0]            rx_byte = 8'h00;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FIRST_HEADER;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            command;
    logic [LEN_W-1:0]      payload_length;
    logic [ADDR_W-1:0]     byte_index;
    logic [7:0]            data_byte;
    logic                  last;

    // Register copy, starting from the reset defaults.
    logic [7:0]  cfg_first = 8'd170;
    logic [7:0]  cfg_second = 8'd85;
    logic [7:0]  cfg_tail = 8'd13;
    logic [15:0] cfg_hdr_to = 16'd10;
    logic [15:0] cfg_pay_to = 16'd20;

    // Deframer state.
    rx_state_t   rx_state = SEEK_H1;
    logic [1:0]  hdr_pos = '0;
    logic [6:0]  data_pos = '0;
    logic [7:0]  cur_cmd = '0;
    logic [6:0]  cur_len = '0;
    logic [7:0]  sum_acc = '0;
    logic        hdr_match = 1'b0;
    logic [7:0]  got_sum = '0;
    logic [15:0] tick_count = '0;
    logic [7:0]  frame_store [MAX_PAYLOAD];

    beat_t       send_q[$];
    frame_byte_t results_due[$];

    int  send_left = 0;
    int  pushed_total = 0;
    int  results_checked = 0;
    int  frames_delivered = 0;
    int  settings_used = 0;
    int  mismatches = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    bit  in_taken = 1'b0;
    bit  idle_enable = 1'b1;
    bit  long_hold_req = 1'b0;

    checksum_frame_receiver_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .rx_byte        (rx_byte),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .command        (command),
        .payload_length (payload_length),
        .byte_index     (byte_index),
        .data_byte      (data_byte),
        .last           (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic deliver_frame();
        frame_byte_t r;
        frames_delivered++;
        if (cur_len == 0)
        begin
            r = '{cmd: cur_cmd, len: '0, idx: '0, data: 8'h00, last: 1'b1};
            results_due.push_back(r);
            return;
        end
        for (int k = 0; k < cur_len; k++)
        begin
            r.cmd  = cur_cmd;
            r.len  = LEN_W'(cur_len);
            r.idx  = ADDR_W'(k);
            r.data = frame_store[k];
            r.last = (k == cur_len - 1);
            results_due.push_back(r);
        end
    endtask

    task automatic back_to_hunt();
        rx_state   = SEEK_H1;
        hdr_pos    = '0;
        data_pos   = '0;
        tick_count = '0;
    endtask

    // Advances the deframer by one accepted beat and queues any frame it completes.
    task automatic absorb_beat(input logic op, input logic [7:0] b);
        logic [15:0] limit;
        if (op == OP_TICK)
        begin
            if (rx_state == SEEK_H1)
                return;
            limit = (rx_state == TAKE_HDR) ? cfg_hdr_to : cfg_pay_to;
            if (tick_count >= limit)
                back_to_hunt();
            else
                tick_count = tick_count + 16'd1;
            return;
        end
        case (rx_state)
            SEEK_H1:
            begin
                if (b == cfg_first)
                begin
                    rx_state   = TAKE_HDR;
                    hdr_pos    = '0;
                    tick_count = '0;
                    sum_acc    = b;
                    hdr_match  = 1'b0;
                end
            end
            TAKE_HDR:
            begin
                sum_acc = sum_acc + b;
                if (hdr_pos == 0)
                begin
                    hdr_match = (b == cfg_second);
                    hdr_pos   = 2'd1;
                end
                else if (hdr_pos == 1)
                begin
                    cur_cmd = b;
                    hdr_pos = 2'd2;
                end
                else if (!hdr_match || b > MAX_PAYLOAD)
                    back_to_hunt();
                else
                begin
                    cur_len    = b[6:0];
                    data_pos   = '0;
                    tick_count = '0;
                    rx_state   = (b == 0) ? TAKE_SUM : TAKE_DATA;
                end
            end
            TAKE_DATA:
            begin
                frame_store[data_pos[5:0]] = b;
                sum_acc  = sum_acc + b;
                data_pos = data_pos + 7'd1;
                if (data_pos >= cur_len)
                    rx_state = TAKE_SUM;
            end
            TAKE_SUM:
            begin
                got_sum  = b;
                rx_state = TAKE_TAIL;
            end
            default:
            begin
                back_to_hunt();
                if (got_sum == sum_acc && b == cfg_tail)
                    deliver_frame();
            end
        endcase
    endtask

    // Input side: present the next beat at the falling edge once the previous one is taken.
    always @(negedge clk)
    begin
        beat_t nxt;
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (send_q.size() == 0)
                in_valid <= 1'b0;
            else if (idle_enable && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(1, 18) - 1;
                in_valid <= 1'b0;
            end
            else
            begin
                nxt = send_q.pop_front();
                in_valid  <= 1'b1;
                operation <= nxt.op;
                rx_byte   <= nxt.value;
            end
        end
    end

    // Output side stall pattern, including the one long hold.
    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 18) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        frame_byte_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result beat: command %0d index %0d data %0d",
                       command, byte_index, data_byte);
                mismatches++;
            end
            else
            begin
                exp_r = results_due.pop_front();
                results_checked++;
                if (command !== exp_r.cmd)
                begin
                    $error("command: expected %0d, actual %0d", exp_r.cmd, command);
                    mismatches++;
                end
                if (payload_length !== exp_r.len)
                begin
                    $error("payload_length: expected %0d, actual %0d",
                           exp_r.len, payload_length);
                    mismatches++;
                end
                if (byte_index !== exp_r.idx)
                begin
                    $error("byte_index: expected %0d, actual %0d", exp_r.idx, byte_index);
                    mismatches++;
                end
                if (data_byte !== exp_r.data)
                begin
                    $error("data_byte: expected %0d, actual %0d", exp_r.data, data_byte);
                    mismatches++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last: expected %0d, actual %0d", exp_r.last, last);
                    mismatches++;
                end
            end
        end
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
        begin
            absorb_beat(operation, rx_byte);
            send_left--;
        end
    end

    task automatic push_beat(input logic op, input logic [7:0] value);
        send_q.push_back('{op: op, value: value});
        send_left++;
        pushed_total++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_FIRST_HEADER:   cfg_first  = value[7:0];
            CFG_SECOND_HEADER:  cfg_second = value[7:0];
            CFG_TAIL_BYTE:      cfg_tail   = value[7:0];
            CFG_HEADER_TIMEOUT: cfg_hdr_to = value;
            default:            cfg_pay_to = value;
        endcase
    endtask

    task automatic apply_setting(input logic [7:0] h1, input logic [7:0] h2,
                                 input logic [7:0] tl, input logic [15:0] hto,
                                 input logic [15:0] pto);
        write_reg(CFG_FIRST_HEADER, {8'h00, h1});
        write_reg(CFG_SECOND_HEADER, {8'h00, h2});
        write_reg(CFG_TAIL_BYTE, {8'h00, tl});
        write_reg(CFG_HEADER_TIMEOUT, hto);
        write_reg(CFG_PAYLOAD_TIMEOUT, pto);
        settings_used++;
    endtask

    // Waits until every beat is taken and every result is back, then lets the parser settle.
    task automatic wait_drained();
        while (send_left != 0 || results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // A few ticks that stay within the timeout, on a quarter of the frames.
    function automatic int stray_ticks(input logic [15:0] limit);
        if ($urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, (limit < 16'd3) ? int'(limit) : 3);
    endfunction

    task automatic push_ticks(input int count);
        repeat (count) push_beat(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic queue_frame(input frame_kind_t kind);
        logic [7:0]  cmd;
        logic [7:0]  len;
        logic [7:0]  sum;
        logic [7:0]  h2;
        logic [7:0]  v;
        int          n;
        int          pick;
        int          tick_at;
        int          pay_ticks;
        frame_kind_t k;
        k = kind;
        // Timeouts are only provoked when the limit is short enough to reach cheaply.
        if (k == FR_HDR_TIMEOUT && cfg_hdr_to > 40)
            k = FR_CLEAN;
        if (k == FR_PAY_TIMEOUT && cfg_pay_to > 40)
            k = FR_CLEAN;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            n = $urandom_range(0, 8);
        else if (pick < 93)
            n = $urandom_range(9, MAX_PAYLOAD - 1);
        else
            n = MAX_PAYLOAD;
        cmd = 8'($urandom_range(0, 255));
        h2  = cfg_second;
        if (k == FR_WRONG_H2)
            h2 = cfg_second ^ 8'($urandom_range(1, 255));
        len = 8'(n);
        if (k == FR_OVERSIZE)
            len = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
        push_beat(OP_BYTE, cfg_first);
        if (k == FR_HDR_TIMEOUT)
        begin
            push_ticks(int'(cfg_hdr_to) + 1);
            return;
        end
        push_ticks(stray_ticks(cfg_hdr_to));
        push_beat(OP_BYTE, h2);
        push_beat(OP_BYTE, cmd);
        push_beat(OP_BYTE, len);
        if (k == FR_WRONG_H2 || k == FR_OVERSIZE)
            return;
        pay_ticks = (k == FR_PAY_TIMEOUT) ? int'(cfg_pay_to) + 1 : stray_ticks(cfg_pay_to);
        tick_at   = $urandom_range(0, n);
        sum       = cfg_first + h2 + cmd + len;
        for (int i = 0; i <= n; i++)
        begin
            if (i == tick_at)
            begin
                push_ticks(pay_ticks);
                if (k == FR_PAY_TIMEOUT)
                    return;
            end
            if (i < n)
            begin
                v   = 8'($urandom_range(0, 255));
                sum = sum + v;
                push_beat(OP_BYTE, v);
            end
        end
        if (k == FR_WRONG_SUM)
            sum = sum ^ 8'($urandom_range(1, 255));
        push_beat(OP_BYTE, sum);
        if (k == FR_WRONG_TAIL)
            push_beat(OP_BYTE, cfg_tail ^ 8'($urandom_range(1, 255)));
        else
            push_beat(OP_BYTE, cfg_tail);
    endtask

    // Stray bytes and ticks between frames; the first header value is avoided
    // so that the following frame still synchronizes.
    task automatic queue_noise();
        logic [7:0] v;
        repeat ($urandom_range(1, 3))
        begin
            v = 8'($urandom_range(0, 255));
            if (v == cfg_first)
                v = v ^ 8'h01;
            push_beat(($urandom_range(0, 2) == 0) ? OP_TICK : OP_BYTE, v);
        end
    endtask

    task automatic run_random(input int budget);
        int goal;
        int pick;
        goal = pushed_total + budget;
        while (pushed_total < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                queue_frame(FR_CLEAN);
            else if (pick < 66)
                queue_frame(FR_WRONG_H2);
            else if (pick < 72)
                queue_frame(FR_WRONG_SUM);
            else if (pick < 78)
                queue_frame(FR_WRONG_TAIL);
            else if (pick < 83)
                queue_frame(FR_OVERSIZE);
            else if (pick < 88)
                queue_frame(FR_HDR_TIMEOUT);
            else if (pick < 93)
                queue_frame(FR_PAY_TIMEOUT);
            else
                queue_noise();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme headers and tail, shortest timeouts.
        apply_setting(8'hFF, 8'h00, 8'hFF, 16'd1, 16'd1);
        push_beat(OP_TICK, 8'h00);
        // Empty frame with one tick at the header limit; checksum FF+00+FF+00.
        push_beat(OP_BYTE, 8'hFF);
        push_beat(OP_TICK, 8'hFF);
        push_beat(OP_BYTE, 8'h00);
        push_beat(OP_BYTE, 8'hFF);
        push_beat(OP_BYTE, 8'h00);
        push_beat(OP_BYTE, 8'hFE);
        push_beat(OP_BYTE, 8'hFF);
        // One tick past the header limit abandons the frame.
        push_beat(OP_BYTE, 8'hFF);
        push_beat(OP_TICK, 8'h00);
        push_beat(OP_TICK, 8'h00);
        // Wrong second header: three bytes are still taken.
        push_beat(OP_BYTE, 8'hFF);
        push_beat(OP_BYTE, 8'h01);
        push_beat(OP_BYTE, 8'h00);
        push_beat(OP_BYTE, 8'h00);
        // Length one above the maximum.
        push_beat(OP_BYTE, 8'hFF);
        push_beat(OP_BYTE, 8'h00);
        push_beat(OP_BYTE, 8'h00);
        push_beat(OP_BYTE, 8'(MAX_PAYLOAD + 1));
        // Payload timeout right after the length byte.
        push_beat(OP_BYTE, 8'hFF);
        push_beat(OP_BYTE, 8'h00);
        push_beat(OP_BYTE, 8'h7F);
        push_beat(OP_BYTE, 8'h01);
        push_beat(OP_TICK, 8'h00);
        push_beat(OP_TICK, 8'h00);
        wait_drained();

        // Longest timeouts; the output is held off while the input keeps offering beats.
        apply_setting(8'hAA, 8'h55, 8'h0D, 16'hFFFF, 16'hFFFF);
        queue_frame(FR_CLEAN);
        run_random(95);
        long_hold_req = 1'b1;
        wait_drained();

        // Opposite header and tail extremes with short timeouts.
        apply_setting(8'h00, 8'hFF, 8'h00, 16'd3, 16'd5);
        run_random(95);
        wait_drained();

        // Random setting; the end of the run goes without idling.
        apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 16'($urandom_range(1, 24)),
                      16'($urandom_range(1, 24)));
        run_random(95);
        while (send_left > 60)
            @(posedge clk);
        idle_enable = 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Sent %0d input beats under %0d register settings,",
                 pushed_total, settings_used);
        $display("with a %0d-cycle output hold; checked %0d result beats from %0d frames.",
                 LONG_HOLD, results_checked, frames_delivered);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
